// ===== hdl/hcb_pkg.sv =====
// hcb_pkg: shared types and constants for the huffman code builder / encoder
// no dependencies
package hcb_pkg;

   localparam int Symbols = 256;
   localparam int SymW = 8;
   localparam int CountW = 16;
   localparam int MaxCodeLen = 24;
   localparam int Nodes = 2 * Symbols - 1;
   localparam int NodeW = 9;
   localparam int LenW = 5;

   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_COUNT = 2'd1;
   localparam logic [1:0] FUNC_BUILD = 2'd2;
   localparam logic [1:0] FUNC_ENCODE = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_ABSENT = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_NOT_BUILT = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic [23:0] code_bits;
      logic [4:0]  code_length;
      logic [1:0]  status;
   } rsp_type;

   // handshake between the command controller and the build sequencer
   typedef struct packed {
      logic start;
   } bld_ctl_type;

   typedef struct packed {
      logic       done;
      logic [1:0] status;
   } bld_sts_type;

endpackage

// ===== hdl/huffman_code_builder_encoder_unit.sv =====
// huffman_code_builder_encoder_unit: top level, command control, histogram and code table
// depends on hcb_pkg, hcb_hist_ram, hcb_builder
//
//   channel   dir   words                         handshake
//   req_      in    hcb_pkg::req_type {func,sym}   req_valid / req_ready
//   rsp_      out   hcb_pkg::rsp_type              rsp_valid / rsp_ready
//
// count and encode words answer after acceptance in steps: histogram or code table
// read (registered), then modify/write back and register the response word;
// with the answer taken at once the next word is accepted in the cycle after
// build runs the tree sequencer: histogram scan, list insertion, merging, a top-down
// walk over the node memory and the code table write
// clear sweeps the histogram one entry a cycle over all 256 entries; reset starts one sweep
// no word is accepted while a response word waits in the output register
module huffman_code_builder_encoder_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  hcb_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output hcb_pkg::rsp_type      rsp_data
);
   localparam logic [2:0] M_CLR = 3'd0;
   localparam logic [2:0] M_IDLE = 3'd1;
   localparam logic [2:0] M_RD = 3'd2;
   localparam logic [2:0] M_EXE = 3'd3;
   localparam logic [2:0] M_BLD = 3'd4;
   localparam logic [2:0] M_OUT = 3'd5;

   localparam int SW = hcb_pkg::SymW;
   localparam int CW = hcb_pkg::CountW;

   logic [2:0]      mode_ff, mode_in;
   logic [SW:0]     clr_ff, clr_in;
   hcb_pkg::req_type cmd_ff, cmd_in;
   hcb_pkg::rsp_type rsp_ff, rsp_in;
   logic [CW-1:0]   total_ff, total_in;
   logic            built_ff, built_in;
   logic            bld_go_ff, bld_go_in;

   // histogram port
   logic            h_we;
   logic [SW-1:0]   h_waddr, h_raddr;
   logic [CW-1:0]   h_wdata, h_rdata, h_bld_rdata;
   logic [SW-1:0]   bld_hist_addr;

   // code table memory
   logic [hcb_pkg::MaxCodeLen-1:0] tabc_mem [hcb_pkg::Symbols];
   logic [hcb_pkg::LenW-1:0]       tabl_mem [hcb_pkg::Symbols];
   logic [hcb_pkg::MaxCodeLen-1:0] tabc_rd_ff;
   logic [hcb_pkg::LenW-1:0]       tabl_rd_ff;
   logic            t_we;
   logic [SW-1:0]   t_addr;
   logic [hcb_pkg::MaxCodeLen-1:0] t_code;
   logic [hcb_pkg::LenW-1:0]       t_len;

   hcb_pkg::bld_ctl_type bctl;
   hcb_pkg::bld_sts_type bsts;

   hcb_hist_ram u_hist (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_waddr),
      .wr_data (h_wdata),
      .rd_addr (h_raddr),
      .rd_data (h_rdata)
   );

   assign h_bld_rdata = h_rdata;
   assign bctl.start = bld_go_ff;

   hcb_builder u_build (
      .clock     (clock),
      .reset     (reset),
      .ctl       (bctl),
      .sts       (bsts),
      .hist_addr (bld_hist_addr),
      .hist_data (h_bld_rdata),
      .tab_we    (t_we),
      .tab_addr  (t_addr),
      .tab_code  (t_code),
      .tab_len   (t_len)
   );

   always_ff @(posedge clock) begin
      if (t_we) begin
         tabc_mem[t_addr] <= t_code;
         tabl_mem[t_addr] <= t_len;
      end
      tabc_rd_ff <= tabc_mem[cmd_ff.symbol];
      tabl_rd_ff <= tabl_mem[cmd_ff.symbol];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_CLR;
         // top bit marks the sweep after reset, which sends no response word
         clr_ff <= {1'b1, SW'(0)};
         total_ff <= '0;
         built_ff <= 1'b0;
         bld_go_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         clr_ff <= clr_in;
         total_ff <= total_in;
         built_ff <= built_in;
         bld_go_ff <= bld_go_in;
      end
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready = (mode_ff == M_IDLE);
   assign rsp_valid = (mode_ff == M_OUT);
   assign rsp_data = rsp_ff;

   always_comb begin
      mode_in = mode_ff;
      clr_in = clr_ff;
      cmd_in = cmd_ff;
      rsp_in = rsp_ff;
      total_in = total_ff;
      built_in = built_ff;
      bld_go_in = 1'b0;
      h_we = 1'b0;
      h_waddr = cmd_ff.symbol;
      h_wdata = h_rdata + CW'(1);
      h_raddr = cmd_ff.symbol;

      unique case (mode_ff)
         M_CLR: begin
            // sweep histogram to zero
            h_we = 1'b1;
            h_waddr = clr_ff[SW-1:0];
            h_wdata = '0;
            clr_in = clr_ff + (SW+1)'(1);
            if (clr_ff[SW-1:0] == SW'(hcb_pkg::Symbols - 1)) begin
               rsp_in = '0;
               rsp_in.status = hcb_pkg::ST_OK;
               mode_in = clr_ff[SW] == 1'b0 && cmd_ff.func == hcb_pkg::FUNC_CLEAR
                  ? M_OUT : M_IDLE;
            end
         end
         M_IDLE: begin
            if (req_valid) begin
               cmd_in = req_data;
               h_raddr = req_data.symbol;
               rsp_in = '0;
               unique case (req_data.func)
                  hcb_pkg::FUNC_CLEAR: begin
                     total_in = '0;
                     built_in = 1'b0;
                     clr_in = '0;
                     mode_in = M_CLR;
                  end
                  hcb_pkg::FUNC_BUILD: begin
                     built_in = 1'b0;
                     bld_go_in = 1'b1;
                     mode_in = M_BLD;
                  end
                  default: begin
                     mode_in = M_RD;
                  end
               endcase
            end
         end
         M_RD: begin
            mode_in = M_EXE;
         end
         M_EXE: begin
            rsp_in = '0;
            if (cmd_ff.func == hcb_pkg::FUNC_COUNT) begin
               if (total_ff == {CW{1'b1}}) begin
                  rsp_in.status = hcb_pkg::ST_OVERFLOW;
               end else begin
                  h_we = 1'b1;
                  total_in = total_ff + CW'(1);
                  built_in = 1'b0;
               end
            end else if (!built_ff) begin
               rsp_in.status = hcb_pkg::ST_NOT_BUILT;
            end else if (h_rdata == '0) begin
               rsp_in.status = hcb_pkg::ST_ABSENT;
            end else begin
               rsp_in.code_bits = tabc_rd_ff;
               rsp_in.code_length = tabl_rd_ff;
            end
            mode_in = M_OUT;
         end
         M_BLD: begin
            h_raddr = bld_hist_addr;
            if (bsts.done) begin
               rsp_in = '0;
               rsp_in.status = bsts.status;
               built_in = (bsts.status == hcb_pkg::ST_OK);
               mode_in = M_OUT;
            end
         end
         M_OUT: begin
            if (rsp_ready) mode_in = M_IDLE;
         end
         default: begin
            mode_in = M_IDLE;
         end
      endcase
   end

   // a response never appears while input is being taken
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("ready and response overlap");
   // an encode always answers on the cycle after its execute step
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == M_EXE && cmd_ff.func == hcb_pkg::FUNC_ENCODE) |=> rsp_valid)
      else $error("encode lost response");
   // total count never wraps
   assert property (@(posedge clock) disable iff (reset)
      $past(total_ff) == {CW{1'b1}} && !$past(mode_ff == M_IDLE) |-> total_ff != '0)
      else $error("total count wrapped");

endmodule

// ===== hdl/hcb_hist_ram.sv =====
// hcb_hist_ram: 256 x 16 histogram memory, one write and one registered read port
// depends on hcb_pkg
module hcb_hist_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [hcb_pkg::SymW-1:0]     wr_addr,
   input  logic [hcb_pkg::CountW-1:0]   wr_data,
   input  logic [hcb_pkg::SymW-1:0]     rd_addr,
   output logic [hcb_pkg::CountW-1:0]   rd_data
);
   logic [hcb_pkg::CountW-1:0] mem [hcb_pkg::Symbols];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hdl/hcb_builder.sv =====
// hcb_builder: tree build sequencer; reads histogram, builds nodes, writes code table
// depends on hcb_pkg
module hcb_builder (
   input  logic                             clock,
   input  logic                             reset,
   input  hcb_pkg::bld_ctl_type             ctl,
   output hcb_pkg::bld_sts_type             sts,
   output logic [hcb_pkg::SymW-1:0]         hist_addr,
   input  logic [hcb_pkg::CountW-1:0]       hist_data,
   output logic                             tab_we,
   output logic [hcb_pkg::SymW-1:0]         tab_addr,
   output logic [hcb_pkg::MaxCodeLen-1:0]   tab_code,
   output logic [hcb_pkg::LenW-1:0]         tab_len
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SCAN = 4'd1;
   localparam logic [3:0] S_INS = 4'd2;
   localparam logic [3:0] S_SHIFT = 4'd3;
   localparam logic [3:0] S_POPA = 4'd4;
   localparam logic [3:0] S_POPB = 4'd5;
   localparam logic [3:0] S_WB = 4'd6;
   localparam logic [3:0] S_MERGE = 4'd7;
   localparam logic [3:0] S_WALK = 4'd8;
   localparam logic [3:0] S_WALK2 = 4'd9;
   localparam logic [3:0] S_EMIT = 4'd10;
   localparam logic [3:0] S_EMIT2 = 4'd11;
   localparam logic [3:0] S_DONE = 4'd12;

   localparam int CW = hcb_pkg::CountW;
   localparam int NW = hcb_pkg::NodeW;
   localparam int LW = hcb_pkg::LenW;
   localparam int ML = hcb_pkg::MaxCodeLen;
   localparam int ScanW = hcb_pkg::SymW + 1;

   // node memories and the ordered list, all flop-free register files modeled as ram
   logic [CW-1:0]   weight_mem [hcb_pkg::Nodes];
   logic [2*NW-1:0] child_mem [hcb_pkg::Nodes];
   logic [NW-1:0]   order_mem [hcb_pkg::Nodes];
   logic [ML-1:0]   ncode_mem [hcb_pkg::Nodes];
   logic [LW:0]     nlen_mem [hcb_pkg::Nodes];

   logic [3:0]      state_ff, state_in;
   logic [ScanW-1:0] scan_ff, scan_in;
   logic            scan_vld_ff;
   logic [NW:0]     len_ff, len_in;      // list length
   logic [NW-1:0]   nodes_ff, nodes_in;  // nodes allocated
   logic [NW-1:0]   leaves_ff, leaves_in;
   logic [NW:0]     pos_ff, pos_in;      // scan position in list
   logic [NW-1:0]   new_ff, new_in;      // node being inserted
   logic [CW-1:0]   neww_ff, neww_in;
   logic [NW-1:0]   a_ff, a_in;
   logic [CW-1:0]   aw_ff, aw_in;
   logic [1:0]      phase_ff, phase_in;
   logic            ovf_ff, ovf_in;
   logic [NW-1:0]   k_ff, k_in;
   logic [NW:0]     head_ff, head_in;
   logic [1:0]      ret_ff, ret_in;      // 0 scan, 1 merge

   // registered read ports
   logic [NW-1:0]   ord_raddr;
   logic [NW-1:0]   ord_rdata_ff;
   logic [NW-1:0]   nd_raddr;
   logic [CW-1:0]   w_rdata_ff;
   logic [2*NW-1:0] c_rdata_ff;
   logic [ML-1:0]   nc_rdata_ff;
   logic [LW:0]     nl_rdata_ff;

   logic            ord_we;
   logic [NW-1:0]   ord_waddr, ord_wdata;
   logic            nd_we;
   logic [NW-1:0]   nd_waddr;
   logic [CW-1:0]   nd_wweight;
   logic [2*NW-1:0] nd_wchild;
   logic            cl_we0, cl_we1;
   logic [NW-1:0]   cl_a0, cl_a1;
   logic [ML-1:0]   cl_c0, cl_c1;
   logic [LW:0]     cl_l;

   always_ff @(posedge clock) begin
      if (ord_we) order_mem[ord_waddr] <= ord_wdata;
      ord_rdata_ff <= order_mem[ord_raddr];
   end

   always_ff @(posedge clock) begin
      if (nd_we) begin
         weight_mem[nd_waddr] <= nd_wweight;
         child_mem[nd_waddr] <= nd_wchild;
      end
      w_rdata_ff <= weight_mem[nd_raddr];
      c_rdata_ff <= child_mem[nd_raddr];
   end

   always_ff @(posedge clock) begin
      if (cl_we0) begin
         ncode_mem[cl_a0] <= cl_c0;
         nlen_mem[cl_a0] <= cl_l;
      end
      if (cl_we1) begin
         ncode_mem[cl_a1] <= cl_c1;
         nlen_mem[cl_a1] <= cl_l;
      end
      nc_rdata_ff <= ncode_mem[nd_raddr];
      nl_rdata_ff <= nlen_mem[nd_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      scan_ff <= scan_in;
      scan_vld_ff <= (state_in == S_SCAN) && (scan_in <= ScanW'(hcb_pkg::Symbols));
      len_ff <= len_in;
      nodes_ff <= nodes_in;
      leaves_ff <= leaves_in;
      pos_ff <= pos_in;
      new_ff <= new_in;
      neww_ff <= neww_in;
      a_ff <= a_in;
      aw_ff <= aw_in;
      phase_ff <= phase_in;
      ovf_ff <= ovf_in;
      k_ff <= k_in;
      head_ff <= head_in;
      ret_ff <= ret_in;
   end

   // insertion sort step: phase 0 issue read of order[pos], phase 1 read its weight, phase 2 compare
   always_comb begin
      state_in = state_ff;
      scan_in = scan_ff;
      len_in = len_ff;
      nodes_in = nodes_ff;
      leaves_in = leaves_ff;
      pos_in = pos_ff;
      new_in = new_ff;
      neww_in = neww_ff;
      a_in = a_ff;
      aw_in = aw_ff;
      phase_in = phase_ff;
      ovf_in = ovf_ff;
      k_in = k_ff;
      head_in = head_ff;
      ret_in = ret_ff;
      hist_addr = scan_ff[hcb_pkg::SymW-1:0];
      ord_raddr = pos_ff[NW-1:0];
      ord_we = 1'b0;
      ord_waddr = '0;
      ord_wdata = '0;
      nd_raddr = ord_rdata_ff;
      nd_we = 1'b0;
      nd_waddr = nodes_ff;
      nd_wweight = '0;
      nd_wchild = '0;
      cl_we0 = 1'b0;
      cl_we1 = 1'b0;
      cl_a0 = '0;
      cl_a1 = '0;
      cl_c0 = '0;
      cl_c1 = '0;
      cl_l = '0;
      tab_we = 1'b0;
      tab_addr = '0;
      tab_code = '0;
      tab_len = '0;
      sts.done = 1'b0;
      sts.status = ovf_ff ? hcb_pkg::ST_OVERFLOW : hcb_pkg::ST_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               state_in = S_SCAN;
               scan_in = '0;
               len_in = '0;
               nodes_in = '0;
               leaves_in = '0;
               head_in = '0;
               ovf_in = 1'b0;
            end
         end
         S_SCAN: begin
            // hist_data is for scan_ff-1 when scan_vld_ff was set previous cycle
            hist_addr = scan_ff[hcb_pkg::SymW-1:0];
            if (scan_vld_ff && scan_ff != '0 && hist_data != '0) begin
               nd_we = 1'b1;
               nd_wweight = hist_data;
               nd_wchild = {NW'(0), NW'(scan_ff - ScanW'(1))};
               new_in = nodes_ff;
               neww_in = hist_data;
               nodes_in = nodes_ff + NW'(1);
               leaves_in = leaves_ff + NW'(1);
               pos_in = '0;
               phase_in = '0;
               ret_in = 2'd0;
               state_in = S_INS;
            end else if (scan_ff >= ScanW'(hcb_pkg::Symbols)) begin
               state_in = S_POPA;
               phase_in = '0;
            end else begin
               scan_in = scan_ff + ScanW'(1);
            end
         end
         S_INS: begin
            // linear search over list for first entry with weight greater than new
            ord_raddr = pos_ff[NW-1:0];
            nd_raddr = ord_rdata_ff;
            if (pos_ff == len_ff) begin
               state_in = S_SHIFT;
               k_in = len_ff[NW-1:0];
            end else if (phase_ff == 2'd0) begin
               phase_in = 2'd1;
            end else if (phase_ff == 2'd1) begin
               phase_in = 2'd2;
            end else begin
               if (w_rdata_ff > neww_ff) begin
                  state_in = S_SHIFT;
                  k_in = len_ff[NW-1:0];
               end else begin
                  pos_in = pos_ff + (NW+1)'(1);
               end
               phase_in = 2'd0;
            end
         end
         S_SHIFT: begin
            // move order[k-1] to order[k] down to pos, then place the new node
            if (k_ff == pos_ff[NW-1:0]) begin
               ord_we = 1'b1;
               ord_waddr = k_ff;
               ord_wdata = new_ff;
               len_in = len_ff + (NW+1)'(1);
               if (ret_ff == 2'd0) begin
                  state_in = S_SCAN;
                  scan_in = scan_ff + ScanW'(1);
               end else begin
                  state_in = S_POPA;
               end
               phase_in = '0;
            end else begin
               ord_raddr = k_ff - NW'(1);
               if (phase_ff == 2'd0) begin
                  phase_in = 2'd1;
               end else begin
                  ord_we = 1'b1;
                  ord_waddr = k_ff;
                  ord_wdata = ord_rdata_ff;
                  k_in = k_ff - NW'(1);
                  phase_in = 2'd0;
               end
            end
         end
         S_POPA: begin
            // take list head; list is kept as a window starting at head
            ord_raddr = head_ff[NW-1:0];
            nd_raddr = ord_rdata_ff;
            if (len_ff - head_ff <= (NW+1)'(1)) begin
               state_in = S_WALK;
               k_in = nodes_ff;
               phase_in = '0;
               if (nodes_ff != '0) begin
                  cl_we0 = 1'b1;
                  cl_a0 = nodes_ff - NW'(1);
                  cl_c0 = '0;
                  cl_l = '0;
               end
            end else if (phase_ff == 2'd0) begin
               phase_in = 2'd1;
            end else if (phase_ff == 2'd1) begin
               phase_in = 2'd2;
            end else begin
               a_in = ord_rdata_ff;
               aw_in = w_rdata_ff;
               head_in = head_ff + (NW+1)'(1);
               phase_in = 2'd0;
               state_in = S_POPB;
            end
         end
         S_POPB: begin
            ord_raddr = head_ff[NW-1:0];
            nd_raddr = ord_rdata_ff;
            if (phase_ff == 2'd0) begin
               phase_in = 2'd1;
            end else if (phase_ff == 2'd1) begin
               phase_in = 2'd2;
            end else begin
               nd_we = 1'b1;
               nd_wweight = aw_ff + w_rdata_ff;
               nd_wchild = {ord_rdata_ff, a_ff};
               new_in = nodes_ff;
               neww_in = aw_ff + w_rdata_ff;
               nodes_in = nodes_ff + NW'(1);
               head_in = head_ff + (NW+1)'(1);
               pos_in = head_ff + (NW+1)'(1);
               phase_in = 2'd0;
               ret_in = 2'd1;
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            // insertion into the window, positions from head upward
            ord_raddr = pos_ff[NW-1:0];
            nd_raddr = ord_rdata_ff;
            if (pos_ff == len_ff) begin
               state_in = S_SHIFT;
               k_in = len_ff[NW-1:0];
            end else if (phase_ff == 2'd0) begin
               phase_in = 2'd1;
            end else if (phase_ff == 2'd1) begin
               phase_in = 2'd2;
            end else begin
               if (w_rdata_ff > neww_ff) begin
                  state_in = S_SHIFT;
                  k_in = len_ff[NW-1:0];
               end else begin
                  pos_in = pos_ff + (NW+1)'(1);
               end
               phase_in = 2'd0;
            end
         end
         S_WALK: begin
            // top-down over inner nodes, root first
            if (k_ff == leaves_ff) begin
               state_in = S_EMIT;
               k_in = '0;
               phase_in = '0;
            end else begin
               nd_raddr = k_ff - NW'(1);
               if (phase_ff == 2'd0) begin
                  phase_in = 2'd1;
               end else begin
                  state_in = S_WALK2;
               end
            end
         end
         S_WALK2: begin
            nd_raddr = k_ff - NW'(1);
            cl_we0 = 1'b1;
            cl_we1 = 1'b1;
            cl_a0 = c_rdata_ff[NW-1:0];
            cl_a1 = c_rdata_ff[2*NW-1:NW];
            cl_c0 = {nc_rdata_ff[ML-2:0], 1'b0};
            cl_c1 = {nc_rdata_ff[ML-2:0], 1'b1};
            cl_l = nl_rdata_ff + (LW+1)'(1);
            if (nl_rdata_ff + (LW+1)'(1) > (LW+1)'(ML)) ovf_in = 1'b1;
            k_in = k_ff - NW'(1);
            phase_in = '0;
            state_in = S_WALK;
         end
         S_EMIT: begin
            if (k_ff == leaves_ff || ovf_ff) begin
               state_in = S_DONE;
            end else begin
               nd_raddr = k_ff;
               if (phase_ff == 2'd0) begin
                  phase_in = 2'd1;
               end else begin
                  state_in = S_EMIT2;
               end
            end
         end
         S_EMIT2: begin
            nd_raddr = k_ff;
            tab_we = 1'b1;
            tab_addr = c_rdata_ff[hcb_pkg::SymW-1:0];
            tab_code = nc_rdata_ff;
            tab_len = nl_rdata_ff[LW-1:0];
            k_in = k_ff + NW'(1);
            phase_in = '0;
            state_in = S_EMIT;
         end
         S_DONE: begin
            sts.done = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule
